>>> sv/nbdrv_pkg.sv
// ----------------------------------------------------------------------------
// nbdrv_pkg
// Shared types and constants for the block-device request header validator.
// ----------------------------------------------------------------------------
package nbdrv_pkg;

  localparam int unsigned ExportW   = 63;
  localparam int unsigned MaxLenW   = 32;
  localparam int unsigned CfgDataW  = 63;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned MagicW    = 32;
  localparam int unsigned CmdW      = 16;
  localparam int unsigned FlagsW    = 16;
  localparam int unsigned OffsetW   = 64;
  localparam int unsigned LengthW   = 32;
  localparam int unsigned SumW      = OffsetW + 1;

  localparam logic [MagicW-1:0]  ReqMagic       = 32'h2560_9513;
  localparam logic [MaxLenW-1:0] DefaultMaxData = MaxLenW'(64 * 1024 * 1024);

  localparam logic [CmdW-1:0] CmdRead  = 16'd0;
  localparam logic [CmdW-1:0] CmdWrite = 16'd1;
  localparam logic [CmdW-1:0] CmdDisc  = 16'd2;
  localparam logic [CmdW-1:0] CmdFlush = 16'd3;
  localparam logic [CmdW-1:0] CmdTrim  = 16'd4;
  localparam logic [CmdW-1:0] CmdWzero = 16'd6;

  localparam int unsigned FlagFuaBit    = 0;
  localparam int unsigned FlagNoHoleBit = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPORT_SIZE   = 3'd0,
    CFG_READ_ONLY     = 3'd1,
    CFG_FLUSH_ALLOWED = 3'd2,
    CFG_TRIM_ALLOWED  = 3'd3,
    CFG_MAX_DATA_LEN  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_EXEC  = 2'd0,
    VERDICT_ERROR = 2'd1,
    VERDICT_DISC  = 2'd2,
    VERDICT_MAGIC = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_PERM  = 3'd1,
    ERR_IO    = 3'd2,
    ERR_NOMEM = 3'd3,
    ERR_INVAL = 3'd4
  } err_e;

  typedef struct packed {
    logic [ExportW-1:0] export_size;
    logic               read_only;
    logic               flush_allowed;
    logic               trim_allowed;
    logic [MaxLenW-1:0] max_data_len;
  } cfg_t;

  typedef struct packed {
    logic [MagicW-1:0]  request_magic;
    logic [CmdW-1:0]    command;
    logic [FlagsW-1:0]  cmd_flags;
    logic [OffsetW-1:0] offset;
    logic [LengthW-1:0] length;
  } req_t;

  typedef struct packed {
    verdict_e verdict;
    err_e     reply_error;
    logic     flush_after;
    logic     drain_payload;
  } rsp_t;

endpackage

>>> sv/nbdrv_cfg.sv
// ----------------------------------------------------------------------------
// nbdrv_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module nbdrv_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nbdrv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nbdrv_pkg::CfgDataW-1:0] cfg_wdata_i,
  output nbdrv_pkg::cfg_t                cfg_o
);
  import nbdrv_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EXPORT_SIZE:   cfg_d.export_size   = cfg_wdata_i[ExportW-1:0];
        CFG_READ_ONLY:     cfg_d.read_only     = cfg_wdata_i[0];
        CFG_FLUSH_ALLOWED: cfg_d.flush_allowed = cfg_wdata_i[0];
        CFG_TRIM_ALLOWED:  cfg_d.trim_allowed  = cfg_wdata_i[0];
        CFG_MAX_DATA_LEN:  cfg_d.max_data_len  = cfg_wdata_i[MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.export_size   <= '0;
      cfg_q.read_only     <= 1'b1;
      cfg_q.flush_allowed <= 1'b0;
      cfg_q.trim_allowed  <= 1'b0;
      cfg_q.max_data_len  <= DefaultMaxData;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/nbdrv_check.sv
// ----------------------------------------------------------------------------
// nbdrv_check
// Request header checks: magic, disconnect, range, flags, size, permissions.
// ----------------------------------------------------------------------------
module nbdrv_check (
  input  nbdrv_pkg::req_t req_i,
  input  nbdrv_pkg::cfg_t cfg_i,
  output nbdrv_pkg::rsp_t rsp_o
);
  import nbdrv_pkg::*;

  logic            is_rw, is_mod, is_ranged, is_flush, is_trim, is_wzero;
  logic [SumW-1:0] range_end;
  logic            range_ok, len_zero, bad_flags, bad_nohole, oversize;
  err_e            err;

  always_comb begin
    is_flush   = (req_i.command == CmdFlush);
    is_trim    = (req_i.command == CmdTrim);
    is_wzero   = (req_i.command == CmdWzero);
    is_rw      = (req_i.command == CmdRead) || (req_i.command == CmdWrite);
    is_mod     = (req_i.command == CmdWrite) || is_flush || is_trim || is_wzero;
    is_ranged  = is_rw || is_trim || is_wzero;
    len_zero   = (req_i.length == '0);
    range_end  = {1'b0, req_i.offset} + SumW'(req_i.length);
    range_ok   = !len_zero && (range_end <= SumW'(cfg_i.export_size));
    bad_flags  = (req_i.cmd_flags[FlagsW-1:FlagNoHoleBit+1] != '0);
    bad_nohole = req_i.cmd_flags[FlagNoHoleBit] && !is_wzero;
    oversize   = is_rw && (req_i.length > cfg_i.max_data_len);
  end

  always_comb begin
    if (is_ranged && !range_ok) begin
      err = ERR_IO;
    end else if (!is_ranged && !is_flush) begin
      err = ERR_INVAL;
    end else if (is_flush && ((req_i.offset != '0) || !len_zero)) begin
      err = ERR_INVAL;
    end else if (bad_flags || bad_nohole) begin
      err = ERR_INVAL;
    end else if (oversize) begin
      err = ERR_NOMEM;
    end else if (cfg_i.read_only && is_mod) begin
      err = ERR_PERM;
    end else if ((!cfg_i.flush_allowed && is_flush) ||
                 (!cfg_i.trim_allowed && is_trim)) begin
      err = ERR_INVAL;
    end else begin
      err = ERR_OK;
    end
  end

  always_comb begin
    rsp_o = '{verdict: VERDICT_EXEC, reply_error: ERR_OK,
              flush_after: 1'b0, drain_payload: 1'b0};
    if (req_i.request_magic != ReqMagic) begin
      rsp_o.verdict = VERDICT_MAGIC;
    end else if (req_i.command == CmdDisc) begin
      rsp_o.verdict = VERDICT_DISC;
    end else if (err != ERR_OK) begin
      rsp_o.verdict       = VERDICT_ERROR;
      rsp_o.reply_error   = err;
      rsp_o.drain_payload = (req_i.command == CmdWrite);
    end else begin
      rsp_o.flush_after = req_i.cmd_flags[FlagFuaBit] && cfg_i.flush_allowed &&
                          !cfg_i.read_only;
    end
  end

endmodule

>>> sv/nbd_request_validator.sv
// ----------------------------------------------------------------------------
// nbd_request_validator
// Validates one decoded block-device request header per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with the header fields. A header is
// taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with verdict, reply error, flush
// and drain flags; exactly one result word per header, in order.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 export size, 1 read only, 2 flush allowed, 3 trim allowed, 4 max data
// length); other indexes are ignored. Write only while the block is idle.
// Path: from the input register through the checks into the result register.
// Throughput: one header per cycle while the output is not stalled; the
// 65-bit range add and compare between the two registers sets the cycle.
// Reset: both pipeline stages empty, registers at their defaults (read only,
// export size 0, no flush or trim, 64 MiB max length).
// Stall: a stalled result holds; the input register still fills behind it,
// and in_stall_o rises only when both stages are full.
// ----------------------------------------------------------------------------
module nbd_request_validator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nbdrv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [nbdrv_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [nbdrv_pkg::MagicW-1:0]    request_magic_i,
  input  logic [nbdrv_pkg::CmdW-1:0]      command_i,
  input  logic [nbdrv_pkg::FlagsW-1:0]    cmd_flags_i,
  input  logic [nbdrv_pkg::OffsetW-1:0]   offset_i,
  input  logic [nbdrv_pkg::LengthW-1:0]   length_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      verdict_o,
  output logic [2:0]                      reply_error_o,
  output logic                            flush_after_o,
  output logic                            drain_payload_o
);
  import nbdrv_pkg::*;

  cfg_t cfg;
  req_t req_q;
  rsp_t rsp, rsp_q;
  logic req_vld_q, rsp_vld_q;
  logic rsp_ready, req_ready;

  nbdrv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  nbdrv_check u_check (
    .req_i (req_q),
    .cfg_i (cfg),
    .rsp_o (rsp)
  );

  assign rsp_ready  = !rsp_vld_q || !out_stall_i;
  assign req_ready  = !req_vld_q || rsp_ready;
  assign in_stall_o = !req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_ready) req_vld_q <= in_valid_i;
      if (rsp_ready) rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready && in_valid_i) begin
      req_q <= '{request_magic: request_magic_i, command: command_i,
                 cmd_flags: cmd_flags_i, offset: offset_i, length: length_i};
    end
    if (rsp_ready && req_vld_q) rsp_q <= rsp;
  end

  assign out_valid_o     = rsp_vld_q;
  assign verdict_o       = rsp_q.verdict;
  assign reply_error_o   = rsp_q.reply_error;
  assign flush_after_o   = rsp_q.flush_after;
  assign drain_payload_o = rsp_q.drain_payload;

endmodule

>>> sv/nbdrv_checker.sv
// ----------------------------------------------------------------------------
// nbdrv_checker
// Port-level assertions for the request header validator.
// ----------------------------------------------------------------------------
module nbdrv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o,
  input logic [2:0] reply_error_o,
  input logic       flush_after_o,
  input logic       drain_payload_o
);
  import nbdrv_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o) &&
    $stable(reply_error_o) && $stable(flush_after_o) && $stable(drain_payload_o))
    else $error("stalled result word changed");

  a_exec_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_EXEC) |->
    (reply_error_o == ERR_OK) && !drain_payload_o)
    else $error("executed word carries an error or drain");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_ERROR) |->
    (reply_error_o != ERR_OK) && !flush_after_o)
    else $error("error reply without code or with flush");

  a_no_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((verdict_o == VERDICT_DISC) || (verdict_o == VERDICT_MAGIC)) |->
    (reply_error_o == ERR_OK) && !flush_after_o && !drain_payload_o)
    else $error("disconnect or bad magic word has side flags");

endmodule

bind nbd_request_validator nbdrv_checker u_nbdrv_checker (.*);
